// ===== rtl/opba_pkg.sv =====
// Package for the oriented primitive bounds accumulator.
// Holds the word types, shape codes and fixed-point constants; no dependencies.
package opba_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned CoefWidth = 17;
  localparam logic [CoefWidth-1:0] CoefMax = 17'h1FFFF;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    ShapeSphere   = 3'd0,
    ShapeCapsule  = 3'd1,
    ShapeCylinder = 3'd2,
    ShapeHalfCyl  = 3'd3,
    ShapeBox      = 3'd4,
    ShapeUnknown  = 3'd5,
    ShapePlane    = 3'd6,
    ShapeCompound = 3'd7
  } shape_e;

  typedef struct packed {
    logic               action;
    logic [2:0]         shape_kind;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] turn_w;
    logic signed [15:0] turn_x;
    logic signed [15:0] turn_y;
    logic signed [15:0] turn_z;
    logic [30:0]        size_a;
    logic [30:0]        size_b;
    logic [30:0]        size_c;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] low_x;
    logic signed [CoordWidth-1:0] low_y;
    logic signed [CoordWidth-1:0] low_z;
    logic signed [CoordWidth-1:0] high_x;
    logic signed [CoordWidth-1:0] high_y;
    logic signed [CoordWidth-1:0] high_z;
    logic                         box_valid;
  } out_word_t;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    logic               clear;
    logic               skip;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] turn_w;
    logic signed [15:0] turn_x;
    logic signed [15:0] turn_y;
    logic signed [15:0] turn_z;
    logic [31:0]        ext_x;
    logic [31:0]        ext_y;
    logic [31:0]        ext_z;
  } task_t;

  function automatic logic [CoefWidth-1:0] coef_f(input logic signed [33:0] e);
    logic [33:0] m;
    logic [33:0] r;
    begin
      m = e[33] ? 34'(-e) : 34'(e);
      r = (m + 34'd8192) >> 14;
      coef_f = (r > 34'(CoefMax)) ? CoefMax : r[CoefWidth-1:0];
    end
  endfunction

endpackage

// ===== rtl/oriented_primitive_bounds_accumulator.sv =====
// Top level of the oriented primitive bounds accumulator.
// Joins opba_front and opba_back; depends on opba_pkg.
//
//  channel | direction | handshake  | word
//  in      | input     | push/full  | in_word_t (in_word_i)
//  out     | output    | pop/empty  | out_word_t (out_word_o)
//
// In the back part a primitive passes the product and coefficient steps, then one multiply
// and sum pair per matrix row, before its result can be popped (a clear or skipped shape
// goes from the product step straight to the output). A two-entry queue lets input words be
// taken while the back part works. Reset empties the queue and clears the box.
// A result held unread stalls the back part, then the queue fills.
module oriented_primitive_bounds_accumulator import opba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  logic      push,
  output logic      full,
  output out_word_t out_word_o,
  output logic      empty,
  input  logic      pop
);

  task_t tk;
  logic  tk_valid, tk_take, res_valid, box_valid;
  logic signed [CoordWidth-1:0] lo [3], hi [3];

  opba_front u_front (
    .clk_i, .rst_ni, .in_word_i, .push_i(push), .full_o(full),
    .task_o(tk), .task_valid_o(tk_valid), .task_take_i(tk_take)
  );

  opba_back u_back (
    .clk_i, .rst_ni, .task_i(tk), .task_valid_i(tk_valid), .task_take_o(tk_take),
    .low_o(lo), .high_o(hi), .box_valid_o(box_valid), .res_valid_o(res_valid),
    .res_take_i(pop)
  );

  assign empty                = ~res_valid;
  assign out_word_o.low_x     = lo[0];
  assign out_word_o.low_y     = lo[1];
  assign out_word_o.low_z     = lo[2];
  assign out_word_o.high_x    = hi[0];
  assign out_word_o.high_y    = hi[1];
  assign out_word_o.high_z    = hi[2];
  assign out_word_o.box_valid = box_valid;

endmodule

// ===== rtl/opba_front.sv =====
// Front part: accepts input words, forms local half extents and queues tasks.
// Depends on opba_pkg.
module opba_front import opba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t in_word_i,
  input  logic     push_i,
  output logic     full_o,
  output task_t    task_o,
  output logic     task_valid_o,
  input  logic     task_take_i
);

  task_t       mem_q [QueueDepth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  task_t       t;
  logic        do_push, do_pop;
  logic [31:0] a32, b32, c32;

  always_comb begin
    a32 = {1'b0, in_word_i.size_a};
    b32 = {1'b0, in_word_i.size_b};
    c32 = {1'b0, in_word_i.size_c};
    t.clear    = ~in_word_i.action;
    t.skip     = (shape_e'(in_word_i.shape_kind) == ShapeUnknown) ||
                 (shape_e'(in_word_i.shape_kind) == ShapePlane);
    t.center_x = in_word_i.center_x;
    t.center_y = in_word_i.center_y;
    t.center_z = in_word_i.center_z;
    t.turn_w   = in_word_i.turn_w;
    t.turn_x   = in_word_i.turn_x;
    t.turn_y   = in_word_i.turn_y;
    t.turn_z   = in_word_i.turn_z;
    t.ext_x    = a32;
    t.ext_y    = b32;
    t.ext_z    = c32;
    unique case (shape_e'(in_word_i.shape_kind))
      ShapeSphere: begin
        t.ext_y = a32;
        t.ext_z = a32;
      end
      ShapeCapsule: begin
        t.ext_y = a32 + b32;
        t.ext_z = a32;
      end
      ShapeCylinder, ShapeHalfCyl: t.ext_z = a32;
      default: ;
    endcase
  end

  assign full_o       = (cnt_q == 2'(QueueDepth));
  assign task_valid_o = (cnt_q != 2'd0);
  assign task_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = task_take_i && task_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QueueDepth)) else $error("queue count overflow");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> cnt_q == 2'(QueueDepth)) else $error("full queue changed");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 && !do_push |=> cnt_q == 2'd0) else $error("empty queue grew");
`endif

endmodule

// ===== rtl/opba_back.sv =====
// Back part: matrix, extent rotation, corner saturation and the running box merge.
// Sequenced by a state machine, one task at a time; depends on opba_pkg.
module opba_back import opba_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  task_t                        task_i,
  input  logic                         task_valid_i,
  output logic                         task_take_o,
  output logic signed [CoordWidth-1:0] low_o [3],
  output logic signed [CoordWidth-1:0] high_o [3],
  output logic                         box_valid_o,
  output logic                         res_valid_o,
  input  logic                         res_take_i
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StProd = 6'b000010,
    StCoef = 6'b000100,
    StMul  = 6'b001000,
    StSum  = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  localparam int unsigned WideW = 52;

  state_e state_q, state_d;
  task_t  t_q;
  logic signed [31:0] p_q [10];
  logic signed [31:0] p_d [10];
  logic [CoefWidth-1:0] cf_q [9];
  logic [CoefWidth-1:0] cf_d [9];
  logic [1:0] row_q;
  logic [48:0] trm_q [3];
  logic [48:0] trm_d [3];
  logic signed [CoordWidth-1:0] lc_q [3], gc_q [3];
  logic has_q;
  logic signed [33:0] e [9];
  logic [31:0] ext_loc [3];
  logic [WideW-1:0] s;
  logic [WideW-1:0] ext;
  logic signed [WideW:0] cw, lo_w, hi_w;
  logic signed [CoordWidth-1:0] lo_s [3], hi_s [3];
  logic signed [CoordWidth-1:0] lo_r_q [3], hi_r_q [3];
  logic signed [WideW:0] cmax, cmin;

  assign ext_loc[0] = t_q.ext_x;
  assign ext_loc[1] = t_q.ext_y;
  assign ext_loc[2] = t_q.ext_z;
  assign cmax = (WideW+1)'((64'sd1 <<< (CoordWidth-1)) - 64'sd1);
  assign cmin = -cmax - (WideW+1)'(1);

  // Products: ww wx wy wz xx xy xz yy yz zz.
  always_comb begin
    p_d[0] = t_q.turn_w * t_q.turn_w;
    p_d[1] = t_q.turn_w * t_q.turn_x;
    p_d[2] = t_q.turn_w * t_q.turn_y;
    p_d[3] = t_q.turn_w * t_q.turn_z;
    p_d[4] = t_q.turn_x * t_q.turn_x;
    p_d[5] = t_q.turn_x * t_q.turn_y;
    p_d[6] = t_q.turn_x * t_q.turn_z;
    p_d[7] = t_q.turn_y * t_q.turn_y;
    p_d[8] = t_q.turn_y * t_q.turn_z;
    p_d[9] = t_q.turn_z * t_q.turn_z;
  end

  always_comb begin
    e[0] = 34'sd268435456 - 34'(2 * (34'(p_q[7]) + 34'(p_q[9])));
    e[1] = 34'(2 * (34'(p_q[5]) - 34'(p_q[3])));
    e[2] = 34'(2 * (34'(p_q[6]) + 34'(p_q[2])));
    e[3] = 34'(2 * (34'(p_q[5]) + 34'(p_q[3])));
    e[4] = 34'sd268435456 - 34'(2 * (34'(p_q[4]) + 34'(p_q[9])));
    e[5] = 34'(2 * (34'(p_q[8]) - 34'(p_q[1])));
    e[6] = 34'(2 * (34'(p_q[6]) - 34'(p_q[2])));
    e[7] = 34'(2 * (34'(p_q[8]) + 34'(p_q[1])));
    e[8] = 34'sd268435456 - 34'(2 * (34'(p_q[4]) + 34'(p_q[7])));
    for (int k = 0; k < 9; k++) begin
      cf_d[k] = coef_f(e[k]);
    end
  end

  // One matrix row per multiply step: three 17x32 products.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      trm_d[j] = 49'(cf_q[4'(row_q * 3 + j)]) * 49'(ext_loc[j]);
    end
  end

  always_comb begin
    s   = WideW'(trm_q[0]) + WideW'(trm_q[1]) + WideW'(trm_q[2]);
    ext = (s + WideW'(8192)) >> 14;
    unique case (row_q)
      2'd0: cw = (WideW+1)'(t_q.center_x);
      2'd1: cw = (WideW+1)'(t_q.center_y);
      default: cw = (WideW+1)'(t_q.center_z);
    endcase
    lo_w = cw - $signed({1'b0, ext});
    hi_w = cw + $signed({1'b0, ext});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (task_valid_i) begin
        state_d = StProd;
      end
      StProd: begin
        if (t_q.clear || t_q.skip) begin
          state_d = StOut;
        end else begin
          state_d = StCoef;
        end
      end
      StCoef: state_d = StMul;
      StMul:  state_d = StSum;
      StSum: begin
        if (row_q == 2'd2) begin
          state_d = StOut;
        end else begin
          state_d = StMul;
        end
      end
      StOut: if (res_take_i) begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign task_take_o = (state_q == StIdle) && task_valid_i;
  assign res_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i) begin
    if (task_take_o) begin
      t_q <= task_i;
    end
    if (state_q == StProd) begin
      p_q <= p_d;
    end
    if (state_q == StCoef) begin
      cf_q <= cf_d;
    end
    if (state_q == StMul) begin
      trm_q <= trm_d;
    end
    if (state_q == StSum) begin
      lo_r_q[row_q] <= (lo_w > cmax) ? cmax[CoordWidth-1:0] :
                       (lo_w < cmin) ? cmin[CoordWidth-1:0] : lo_w[CoordWidth-1:0];
      hi_r_q[row_q] <= (hi_w > cmax) ? cmax[CoordWidth-1:0] :
                       (hi_w < cmin) ? cmin[CoordWidth-1:0] : hi_w[CoordWidth-1:0];
    end
  end

  always_comb begin
    lo_s = lo_r_q;
    hi_s = hi_r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= 2'd0;
      has_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lc_q[i] <= '0;
        gc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == StCoef) begin
        row_q <= 2'd0;
      end else if (state_q == StSum && row_q != 2'd2) begin
        row_q <= row_q + 2'd1;
      end
      if (state_q == StProd && t_q.clear) begin
        has_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          lc_q[i] <= '0;
          gc_q[i] <= '0;
        end
      end else if (state_q == StSum && row_q == 2'd2) begin
        has_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (!has_q) begin
            lc_q[i] <= (i == 2) ? ((lo_w > cmax) ? cmax[CoordWidth-1:0] :
                       (lo_w < cmin) ? cmin[CoordWidth-1:0] : lo_w[CoordWidth-1:0])
                       : lo_s[i];
            gc_q[i] <= (i == 2) ? ((hi_w > cmax) ? cmax[CoordWidth-1:0] :
                       (hi_w < cmin) ? cmin[CoordWidth-1:0] : hi_w[CoordWidth-1:0])
                       : hi_s[i];
          end else begin
            if (((i == 2) ? lo_w : (WideW+1)'(lo_s[i])) < (WideW+1)'(lc_q[i])) begin
              lc_q[i] <= (i == 2) ? ((lo_w < cmin) ? cmin[CoordWidth-1:0] :
                         lo_w[CoordWidth-1:0]) : lo_s[i];
            end
            if (((i == 2) ? hi_w : (WideW+1)'(hi_s[i])) > (WideW+1)'(gc_q[i])) begin
              gc_q[i] <= (i == 2) ? ((hi_w > cmax) ? cmax[CoordWidth-1:0] :
                         hi_w[CoordWidth-1:0]) : hi_s[i];
            end
          end
        end
      end
    end
  end

  assign low_o       = lc_q;
  assign high_o      = gc_q;
  assign box_valid_o = has_q;

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != 2'd3) else $error("row out of range");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StProd && t_q.clear |=> !has_q) else $error("clear missed");
`endif

endmodule
